@@ hw/rtl/stepper_position_sequencer_macros.svh @@
// assertion macros for the stepper position sequencer
`ifndef STEPPER_POSITION_SEQUENCER_MACROS_SVH
`define STEPPER_POSITION_SEQUENCER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stepper position sequencer check failed");

// next-cycle implication, checked out of reset
`define SPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stepper position sequencer check failed");

`endif

@@ hw/rtl/sps_pkg.sv @@
// shared types, constants and helpers for the stepper position sequencer
package sps_pkg;

    localparam int unsigned TIMER_W      = 16;
    localparam int unsigned PENDING_W    = 32;
    localparam int unsigned COUNT_W      = 16;
    localparam int unsigned COILS_W      = 4;

    localparam logic [TIMER_W-1:0] TIMER_MAX          = '1;
    localparam logic [TIMER_W-1:0] STEP_INTERVAL_RST  = 16'd1900;

    // request codes
    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_MOVE = 1'b1
    } sps_req_t;

    // motion state carried from item to item
    typedef struct packed {
        logic [TIMER_W-1:0]          elapsed;
        logic [1:0]                  phase;
        logic signed [PENDING_W-1:0] pending;
        logic                        energised;
    } sps_state_t;

    // result of one item
    typedef struct packed {
        logic [COILS_W-1:0] coils;
        logic               coils_enabled;
        logic               sleep_request;
        logic               at_target;
    } sps_result_t;

    // full-step coil pattern for each phase
    function automatic logic [COILS_W-1:0] phase_pattern(input logic [1:0] phase);
        logic [COILS_W-1:0] pat;
        case (phase)
            2'd0:    pat = 4'd12;
            2'd1:    pat = 4'd6;
            2'd2:    pat = 4'd3;
            default: pat = 4'd9;
        endcase
        return pat;
    endfunction

endpackage

@@ hw/rtl/sps_step_logic.sv @@
// next-state and result logic for one tick or move item
module sps_step_logic
(
    input  sps_pkg::sps_state_t            state,
    input  logic [sps_pkg::TIMER_W-1:0]    step_interval,
    input  logic                           req_type,
    input  logic signed [sps_pkg::COUNT_W-1:0] move_count,
    input  logic                           powerup_phase,
    output sps_pkg::sps_state_t            state_next,
    output sps_pkg::sps_result_t           result
);

    logic signed [sps_pkg::PENDING_W:0] sum_wide;
    logic                               sum_ovf;
    logic signed [sps_pkg::PENDING_W-1:0] pending_sat;
    logic [sps_pkg::TIMER_W-1:0]        elapsed_inc;
    logic                               expired;
    logic                               pending_zero;
    logic                               sleep;

    // saturating add of the move count to the pending steps
    always_comb
    begin
        sum_wide = {state.pending[sps_pkg::PENDING_W-1], state.pending}
                 + {{(sps_pkg::PENDING_W + 1 - sps_pkg::COUNT_W){move_count[sps_pkg::COUNT_W-1]}},
                    move_count};
        sum_ovf  = sum_wide[sps_pkg::PENDING_W] != sum_wide[sps_pkg::PENDING_W-1];
        if (!sum_ovf)
        begin
            pending_sat = sum_wide[sps_pkg::PENDING_W-1:0];
        end
        else if (sum_wide[sps_pkg::PENDING_W])
        begin
            pending_sat = {1'b1, {(sps_pkg::PENDING_W-1){1'b0}}};
        end
        else
        begin
            pending_sat = {1'b0, {(sps_pkg::PENDING_W-1){1'b1}}};
        end
    end

    // saturating timer and expiry check
    assign elapsed_inc  = (state.elapsed == sps_pkg::TIMER_MAX) ? state.elapsed
                                                                : state.elapsed + 1'b1;
    assign expired      = elapsed_inc >= step_interval;
    assign pending_zero = state.pending == '0;

    // state update
    always_comb
    begin
        state_next = state;
        sleep      = 1'b0;
        if (req_type == sps_pkg::REQ_MOVE)
        begin
            state_next.pending = pending_sat;
        end
        else
        begin
            state_next.elapsed = elapsed_inc;
            if (expired)
            begin
                if (pending_zero)
                begin
                    state_next.energised = 1'b0;
                    sleep                = !powerup_phase;
                end
                else if (!state.energised)
                begin
                    state_next.energised = 1'b1;
                    state_next.elapsed   = '0;
                end
                else
                begin
                    // positive pending steps the phase down, negative steps it up
                    if (!state.pending[sps_pkg::PENDING_W-1])
                    begin
                        state_next.phase   = state.phase - 2'd1;
                        state_next.pending = state.pending - 1;
                    end
                    else
                    begin
                        state_next.phase   = state.phase + 2'd1;
                        state_next.pending = state.pending + 1;
                    end
                    state_next.elapsed = '0;
                end
            end
        end
    end

    // result from the updated state
    always_comb
    begin
        result.coils         = state_next.energised ? sps_pkg::phase_pattern(state_next.phase)
                                                    : '0;
        result.coils_enabled = state_next.energised;
        result.sleep_request = sleep;
        result.at_target     = state_next.pending == '0;
    end

endmodule

@@ hw/rtl/stepper_position_sequencer.sv @@
// Full-step stepper position sequencer: takes one tick or move item per clock
// and returns one result per item (coil drive, enable, sleep request, at-target),
// registered in the cycle after the transfer. The throughput is one item per clock; the
// only limit is the single result register, which holds a result until it is
// taken, so input stalls only while a result waits and the output is stalled.
// step_interval resets to 1900 ticks and the timer starts expired.
`include "stepper_position_sequencer_macros.svh"

module stepper_position_sequencer
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [sps_pkg::TIMER_W-1:0]        cfg_wr_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic signed [sps_pkg::COUNT_W-1:0] move_count,
    input  logic                               powerup_phase,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sps_pkg::COILS_W-1:0]        coils,
    output logic                               coils_enabled,
    output logic                               sleep_request,
    output logic                               at_target
);

    logic [sps_pkg::TIMER_W-1:0] step_interval_reg;
    sps_pkg::sps_state_t         state_reg;
    sps_pkg::sps_state_t         state_next;
    sps_pkg::sps_result_t        result_reg;
    sps_pkg::sps_result_t        result_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        in_accept;

    // handshake
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_interval_reg <= sps_pkg::STEP_INTERVAL_RST;
        end
        else if (cfg_wr_en)
        begin
            step_interval_reg <= cfg_wr_data;
        end
    end

    // per-item logic
    sps_step_logic u_step
    (
        .state         (state_reg),
        .step_interval (step_interval_reg),
        .req_type      (req_type),
        .move_count    (move_count),
        .powerup_phase (powerup_phase),
        .state_next    (state_next),
        .result        (result_next)
    );

    // motion state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.elapsed   <= sps_pkg::STEP_INTERVAL_RST;
            state_reg.phase     <= '0;
            state_reg.pending   <= '0;
            state_reg.energised <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    // result register, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign coils         = result_reg.coils;
    assign coils_enabled = result_reg.coils_enabled;
    assign sleep_request = result_reg.sleep_request;
    assign at_target     = result_reg.at_target;

    // checks
    `SPS_ASSERT_NOW(a_coils_off_when_disabled, out_valid_reg && !result_reg.coils_enabled, result_reg.coils == '0)
    `SPS_ASSERT_NOW(a_sleep_only_idle, out_valid_reg && result_reg.sleep_request, result_reg.at_target && !result_reg.coils_enabled)
    `SPS_ASSERT_NOW(a_target_tracks_pending, out_valid_reg, result_reg.at_target == (state_reg.pending == '0))
    `SPS_ASSERT_NEXT(a_move_keeps_coils, in_accept && req_type == sps_pkg::REQ_MOVE, state_reg.energised == $past(state_reg.energised) && state_reg.phase == $past(state_reg.phase))

endmodule

@@ bench/tb_stepper_position_sequencer.sv @@
// self-checking testbench for the stepper position sequencer
`timescale 1ns / 1ps

module tb_stepper_position_sequencer;

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 300;
    localparam int MAX_REPORTS    = 10;

    // full-step coil drive by phase
    localparam logic [sps_pkg::COILS_W-1:0] FULL_STEP [4] = '{4'd12, 4'd6, 4'd3, 4'd9};

    typedef struct {
        sps_pkg::sps_req_t                  req;
        logic signed [sps_pkg::COUNT_W-1:0] count;
        logic                               powerup;
    } motor_req_t;

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               cfg_wr_en     = 1'b0;
    logic [sps_pkg::TIMER_W-1:0]        cfg_wr_data   = '0;
    logic                               in_valid      = 1'b0;
    logic                               in_stall;
    logic                               req_type      = 1'b0;
    logic signed [sps_pkg::COUNT_W-1:0] move_count    = '0;
    logic                               powerup_phase = 1'b0;
    logic                               out_valid;
    logic                               out_stall     = 1'b0;
    logic [sps_pkg::COILS_W-1:0]        coils;
    logic                               coils_enabled;
    logic                               sleep_request;
    logic                               at_target;

    // motion state as the block should hold it
    logic [sps_pkg::TIMER_W-1:0]          interval_set       = sps_pkg::STEP_INTERVAL_RST;
    logic [sps_pkg::TIMER_W-1:0]          ticks_since_change = sps_pkg::STEP_INTERVAL_RST;
    logic [1:0]                           phase_now          = 2'd0;
    logic signed [sps_pkg::PENDING_W-1:0] steps_left         = '0;
    logic                                 coils_on           = 1'b0;

    motor_req_t           req_backlog[$];
    sps_pkg::sps_result_t coil_results_due[$];
    motor_req_t           offered_req;

    bit no_gaps     = 1'b0;
    int hold_asks   = 0;
    int holds_done  = 0;
    int send_gap    = 0;
    int stall_left  = 0;
    int mismatches  = 0;
    int idle_cycles = 0;

    stepper_position_sequencer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .move_count    (move_count),
        .powerup_phase (powerup_phase),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coils         (coils),
        .coils_enabled (coils_enabled),
        .sleep_request (sleep_request),
        .at_target     (at_target)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // apply one request to the motion state and return the coil drive after it
    function automatic sps_pkg::sps_result_t advance_motor(input motor_req_t r);
        sps_pkg::sps_result_t               res;
        logic signed [sps_pkg::PENDING_W:0] sum;
        logic                               sleep;
        sleep = 1'b0;
        if (r.req == sps_pkg::REQ_MOVE)
        begin
            // saturate at the signed 32-bit limits
            sum = steps_left + r.count;
            if (sum[sps_pkg::PENDING_W] != sum[sps_pkg::PENDING_W-1])
                steps_left = sum[sps_pkg::PENDING_W]
                           ? {1'b1, {(sps_pkg::PENDING_W-1){1'b0}}}
                           : {1'b0, {(sps_pkg::PENDING_W-1){1'b1}}};
            else
                steps_left = sum[sps_pkg::PENDING_W-1:0];
        end
        else
        begin
            if (ticks_since_change != '1)
                ticks_since_change = ticks_since_change + 1'b1;
            if (ticks_since_change >= interval_set)
            begin
                if (steps_left == 0)
                begin
                    coils_on = 1'b0;
                    sleep    = !r.powerup;
                end
                else if (!coils_on)
                begin
                    coils_on           = 1'b1;
                    ticks_since_change = '0;
                end
                else
                begin
                    if (steps_left > 0)
                    begin
                        phase_now  = phase_now - 2'd1;
                        steps_left = steps_left - 1;
                    end
                    else
                    begin
                        phase_now  = phase_now + 2'd1;
                        steps_left = steps_left + 1;
                    end
                    ticks_since_change = '0;
                end
            end
        end
        res.coils         = coils_on ? FULL_STEP[phase_now] : '0;
        res.coils_enabled = coils_on;
        res.sleep_request = sleep;
        res.at_target     = (steps_left == 0);
        return res;
    endfunction

    // request driver: one transfer per pending request, random gap after each unless no_gaps is set
    always @(posedge clk)
    begin : driver
        logic offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            offer = in_valid;
            if (in_valid && !in_stall)
            begin
                coil_results_due.push_back(advance_motor(offered_req));
                offer    = 1'b0;
                send_gap = no_gaps ? 0 : $urandom_range(0, 3);
            end
            if (!offer)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (req_backlog.size() > 0)
                begin
                    offered_req = req_backlog.pop_front();
                    req_type      <= offered_req.req;
                    move_count    <= offered_req.count;
                    powerup_phase <= offered_req.powerup;
                    offer = 1'b1;
                end
            end
            in_valid <= offer;
        end
    end

    // result monitor and output stall
    always @(posedge clk)
    begin : monitor
        sps_pkg::sps_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (coil_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result transfer with nothing expected: coils %h",
                                 $time, coils);
                end
                else
                begin
                    want = coil_results_due.pop_front();
                    if (coils !== want.coils || coils_enabled !== want.coils_enabled ||
                        sleep_request !== want.sleep_request ||
                        at_target !== want.at_target)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: exp/act coils %h/%h en %b/%b sleep %b/%b tgt %b/%b",
                                     $time, want.coils, coils,
                                     want.coils_enabled, coils_enabled,
                                     want.sleep_request, sleep_request,
                                     want.at_target, at_target);
                    end
                end
                stall_left = no_gaps ? 0 : $urandom_range(0, 3);
            end
            // long back-pressure on request
            if (hold_asks != holds_done)
            begin
                holds_done++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic queue_tick(input logic pu);
        motor_req_t r;
        r.req     = sps_pkg::REQ_TICK;
        r.count   = sps_pkg::COUNT_W'($urandom());
        r.powerup = pu;
        req_backlog.push_back(r);
    endtask

    task automatic queue_move(input logic signed [sps_pkg::COUNT_W-1:0] c);
        motor_req_t r;
        r.req     = sps_pkg::REQ_MOVE;
        r.count   = c;
        r.powerup = 1'($urandom_range(0, 1));
        req_backlog.push_back(r);
    endtask

    // wait until every request is sent and every result checked
    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || in_valid || coil_results_due.size() != 0);
    endtask

    task automatic write_interval(input logic [sps_pkg::TIMER_W-1:0] v);
        wait_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        interval_set = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= sps_pkg::TIMER_W'($urandom());
    endtask

    // cancel whatever is pending so the motor ends at its target
    task automatic settle();
        longint p;
        longint c;
        wait_idle();
        p = steps_left;
        while (p != 0)
        begin
            if (p > 0)
                c = (p > 32768) ? -32768 : -p;
            else
                c = (p < -32767) ? 32767 : -p;
            queue_move(sps_pkg::COUNT_W'(c));
            p += c;
        end
        queue_tick(1'b0);
    endtask

    // mostly move-then-run sequences, some large moves and noise
    task automatic random_phase(input int n_items, input bit with_hold);
        int made;
        int c;
        int k;
        int n;
        logic signed [sps_pkg::COUNT_W-1:0] big;
        made = 0;
        while (made < n_items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    c = $urandom_range(0, 10) - 5;
                    queue_move(sps_pkg::COUNT_W'(c));
                    k = ((c < 0 ? -c : c) + 2) * (interval_set + 1) + $urandom_range(0, 3);
                    repeat (k) queue_tick(1'($urandom_range(0, 1)));
                    made += 1 + k;
                end
                6:
                begin
                    big = sps_pkg::COUNT_W'($urandom());
                    queue_move(big);
                    n = $urandom_range(0, 4);
                    repeat (n) queue_tick(1'($urandom_range(0, 1)));
                    if (big == -16'sd32768)
                    begin
                        queue_move(16'sd32767);
                        queue_move(16'sd1);
                        made += 3 + n;
                    end
                    else
                    begin
                        queue_move(-big);
                        made += 2 + n;
                    end
                end
                default:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        c = $urandom_range(0, 6) - 3;
                        if ($urandom_range(0, 1))
                            queue_tick(1'($urandom_range(0, 1)));
                        else
                            queue_move(sps_pkg::COUNT_W'(c));
                    end
                    made += n;
                end
            endcase
        end
        if (with_hold)
            hold_asks++;
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset interval, timer starts expired
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_move(16'sd1);
        queue_tick(1'b0);
        queue_tick(1'b0);

        // zero interval: every tick is expired
        write_interval(16'd0);
        queue_tick(1'b0);
        queue_tick(1'b0);
        queue_move(-16'sd32768);
        queue_move(16'sd32767);
        queue_move(16'sd0);
        queue_tick(1'b0);
        queue_move(-16'sd3);
        repeat (4) queue_tick(1'b0);
        queue_tick(1'b1);

        // longest interval, then shortened without touching the timer
        write_interval(16'hFFFF);
        queue_move(16'sd1);
        queue_tick(1'b0);
        write_interval(16'd1);
        repeat (3) queue_tick(1'b0);
        settle();

        // random sequences over several intervals
        write_interval(16'd0);
        random_phase(PHASE_ITEMS, 1'b1);
        write_interval(16'd1);
        random_phase(PHASE_ITEMS, 1'b0);
        write_interval(16'd2);
        no_gaps = 1'b1;
        random_phase(PHASE_ITEMS, 1'b0);
        wait_idle();
        no_gaps = 1'b0;
        write_interval(16'd3);
        random_phase(PHASE_ITEMS, 1'b0);
        write_interval(sps_pkg::TIMER_W'($urandom_range(4, 8)));
        random_phase(PHASE_ITEMS, 1'b0);

        wait_idle();
        repeat (5) @(posedge clk);
        if (mismatches == 0 && coil_results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
